// ----- src/svnu_pkg.sv -----
// Shared types, constants and codes for the signed voter node update engine.
// Depends on nothing; every other file of the block imports it.
package svnu_pkg;

    localparam int NODES       = 1024;
    localparam int NODE_W      = 10;
    localparam int MAX_DEGREE  = 16;
    localparam int SLOT_W      = 4;
    localparam int DEG_W       = 5;
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = 4;
    localparam int QCNT_W      = 5;
    localparam int MAX_GROUP   = 8;
    localparam int GRP_W       = 4;
    localparam int WORD_W      = 64;
    localparam int WT_W        = 16;
    localparam int H_W         = 22;
    localparam int MOD_BITS    = 4;
    localparam int MOD_STEPS   = WORD_W / MOD_BITS;
    localparam int MCNT_W      = 4;
    localparam int USED_W      = 4;

    localparam logic [2:0] OP_WSPIN = 3'd0;
    localparam logic [2:0] OP_WDEG  = 3'd1;
    localparam logic [2:0] OP_WEDGE = 3'd2;
    localparam logic [2:0] OP_PUSH  = 3'd3;
    localparam logic [2:0] OP_ASYNC = 3'd4;
    localparam logic [2:0] OP_SYNC  = 3'd5;
    localparam logic [2:0] OP_SWAP  = 3'd6;
    localparam logic [2:0] OP_READ  = 3'd7;

    localparam logic [1:0] RULE_LINEAR = 2'd0;
    localparam logic [1:0] RULE_MAJ    = 2'd1;
    localparam logic [1:0] RULE_QV     = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] REG_RULE  = 2'd0;
    localparam logic [1:0] REG_GROUP = 2'd1;
    localparam logic [1:0] REG_FLIP  = 2'd2;

    localparam logic [2:0] RES_KEEP  = 3'd0;
    localparam logic [2:0] RES_SIGMA = 3'd1;
    localparam logic [2:0] RES_FIRST = 3'd2;
    localparam logic [2:0] RES_ONE   = 3'd3;
    localparam logic [2:0] RES_ZERO  = 3'd4;
    localparam logic [2:0] RES_TIE   = 3'd5;
    localparam logic [2:0] RES_FLIP  = 3'd6;

    typedef struct packed {
        logic       capture;
        logic       clr_en;
        logic       simple;
        logic       rd_self;
        logic       take_self;
        logic       mod_start;
        logic       mod_step;
        logic       nt_rd;
        logic       sp_rd;
        logic       sg_take;
        logic       acc;
        logic       word_take;
        logic       k_inc;
        logic       finish;
        logic       abort;
        logic [2:0] res;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       deg_zero;
        logic       avail;
        logic       mod_done;
        logic       idx_last;
        logic       h_zero;
        logic       h_pos;
        logic       sg_diff;
        logic       k_last;
        logic       out_busy;
        logic [2:0] op;
        logic [1:0] rule;
    } t_sts;

endpackage

// ----- src/svnu_ctrl.sv -----
// Sequencing state machine of the signed voter node update engine.
// Depends on svnu_pkg; drives the datapath svnu_dp through t_cmd.
module svnu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  svnu_pkg::t_sts i_sts,
    output svnu_pkg::t_cmd o_cmd
);
    import svnu_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_SELF = 4'd3;
    localparam logic [3:0] S_RULE = 4'd4;
    localparam logic [3:0] S_DRAW = 4'd5;
    localparam logic [3:0] S_MOD  = 4'd6;
    localparam logic [3:0] S_NT   = 4'd7;
    localparam logic [3:0] S_SP   = 4'd8;
    localparam logic [3:0] S_SG   = 4'd9;
    localparam logic [3:0] S_QCHK = 4'd10;
    localparam logic [3:0] S_HCHK = 4'd11;
    localparam logic [3:0] S_WORD = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] r_state, n_state;
    logic [2:0] r_res, n_res;
    logic       r_abort, n_abort;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_abort     = r_abort;
        o_cmd       = '0;
        o_cmd.res   = r_res;
        o_cmd.abort = r_abort;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_abort       = 1'b0;
                    n_res         = RES_KEEP;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op inside {OP_ASYNC, OP_SYNC, OP_READ}) begin
                    o_cmd.rd_self = 1'b1;
                    n_state       = S_SELF;
                end else begin
                    o_cmd.simple = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_SELF: begin
                o_cmd.take_self = 1'b1;
                n_state = (i_sts.op == OP_READ) ? S_FIN : S_RULE;
            end
            S_RULE: begin
                if (i_sts.deg_zero) begin
                    n_state = S_FIN;
                end else begin
                    case (i_sts.rule)
                        RULE_LINEAR: n_state = S_DRAW;
                        RULE_QV:     n_state = S_DRAW;
                        RULE_MAJ:    n_state = S_NT;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_DRAW: begin
                if (!i_sts.avail) begin
                    n_abort = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) n_state = S_NT;
            end
            S_NT: begin
                o_cmd.nt_rd = 1'b1;
                n_state     = S_SP;
            end
            S_SP: begin
                o_cmd.sp_rd = 1'b1;
                n_state     = S_SG;
            end
            S_SG: begin
                case (i_sts.rule)
                    RULE_MAJ: begin
                        o_cmd.acc = 1'b1;
                        n_state   = i_sts.idx_last ? S_HCHK : S_NT;
                    end
                    RULE_LINEAR: begin
                        o_cmd.sg_take = 1'b1;
                        n_res         = RES_SIGMA;
                        n_state       = S_FIN;
                    end
                    default: begin
                        o_cmd.sg_take = 1'b1;
                        n_state       = S_QCHK;
                    end
                endcase
            end
            S_QCHK: begin
                if (i_sts.sg_diff) begin
                    n_res   = RES_FLIP;
                    n_state = S_WORD;
                end else if (i_sts.k_last) begin
                    n_res   = RES_FIRST;
                    n_state = S_FIN;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_DRAW;
                end
            end
            S_HCHK: begin
                if (i_sts.h_pos) begin
                    n_res   = RES_ONE;
                    n_state = S_FIN;
                end else if (i_sts.h_zero) begin
                    n_res   = RES_TIE;
                    n_state = S_WORD;
                end else begin
                    n_res   = RES_ZERO;
                    n_state = S_FIN;
                end
            end
            S_WORD: begin
                if (!i_sts.avail) begin
                    n_abort = 1'b1;
                end else begin
                    o_cmd.word_take = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_res   <= RES_KEEP;
            r_abort <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_abort <= n_abort;
        end
    end

endmodule

// ----- src/svnu_dp.sv -----
// Datapath of the signed voter node update engine: memories, random queue,
// modulo unit, accumulator and output register. Depends on svnu_pkg.
module svnu_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  svnu_pkg::t_cmd                     i_cmd,
    output svnu_pkg::t_sts                     o_sts,
    input  logic [1:0]                         i_rule_select,
    input  logic [svnu_pkg::GRP_W-1:0]         i_group_size,
    input  logic [16:0]                        i_flip_chance,
    input  logic [2:0]                         i_opcode,
    input  logic [svnu_pkg::NODE_W-1:0]        i_node,
    input  logic [svnu_pkg::SLOT_W-1:0]        i_slot,
    input  logic [svnu_pkg::NODE_W-1:0]        i_neighbour,
    input  logic signed [svnu_pkg::WT_W-1:0]   i_edge_weight,
    input  logic                               i_spin_in,
    input  logic [svnu_pkg::DEG_W-1:0]         i_degree_in,
    input  logic [svnu_pkg::WORD_W-1:0]        i_random_word,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_spin_out,
    output logic [1:0]                         o_status,
    output logic [svnu_pkg::USED_W-1:0]        o_words_used,
    output logic [svnu_pkg::QCNT_W-1:0]        o_queue_level
);
    import svnu_pkg::*;

    // Captured item.
    logic [2:0]             r_op;
    logic [NODE_W-1:0]      r_node;
    logic [SLOT_W-1:0]      r_slot;
    logic [NODE_W-1:0]      r_nb;
    logic signed [WT_W-1:0] r_wt;
    logic                   r_spin;
    logic [DEG_W-1:0]       r_deg_in;
    logic [WORD_W-1:0]      r_rw;

    // Memories.
    logic                   r_spin_mem [0:2*NODES-1];
    logic                   r_spin_q;
    logic [DEG_W-1:0]       r_deg_mem [0:NODES-1];
    logic [DEG_W-1:0]       r_deg_q;
    logic [NODE_W-1:0]      r_nt_mem [0:NODES*MAX_DEGREE-1];
    logic [WT_W-1:0]        r_wt_mem [0:NODES*MAX_DEGREE-1];
    logic [NODE_W-1:0]      r_nt_q;
    logic [WT_W-1:0]        r_wt_q;
    logic [WORD_W-1:0]      r_queue [0:QUEUE_DEPTH-1];

    // Control state.
    logic                   r_act;
    logic [QCNT_W-1:0]      r_count;
    logic [QPTR_W-1:0]      r_head;
    logic [NODE_W-1:0]      r_clr_idx;
    logic                   r_full;

    // Update working registers.
    logic [DEG_W-1:0]       r_deg;
    logic                   r_cur;
    logic [WORD_W-1:0]      r_div;
    logic [DEG_W-1:0]       r_rem;
    logic [MCNT_W-1:0]      r_mcnt;
    logic [USED_W-1:0]      r_n;
    logic [SLOT_W-1:0]      r_idx;
    logic [GRP_W-1:0]       r_k;
    logic signed [H_W-1:0]  r_h;
    logic [WT_W-1:0]        r_w;
    logic                   r_sg;
    logic                   r_first;
    logic                   r_tie;
    logic                   r_flip;

    // Output register.
    logic                   r_ov;
    logic                   r_o_spin;
    logic [1:0]             r_o_status;
    logic [USED_W-1:0]      r_o_used;
    logic [QCNT_W-1:0]      r_o_level;

    logic                   is_update;
    logic                   commit;
    logic                   res_spin;
    logic                   sigma;
    logic [WORD_W-1:0]      word_cur;
    logic [GRP_W-1:0]       q_eff;
    logic [DEG_W-1:0]       rem_next;
    logic [SLOT_W-1:0]      nt_sel;
    logic                   spin_we, spin_re, spin_wd;
    logic [NODE_W:0]        spin_wa, spin_ra;
    logic                   deg_we;
    logic [NODE_W-1:0]      deg_wa;
    logic [DEG_W-1:0]       deg_wd;
    logic                   nt_we;
    logic signed [H_W-1:0]  w_ext;

    assign is_update = (r_op == OP_ASYNC) || (r_op == OP_SYNC);
    assign commit    = i_cmd.finish && !i_cmd.abort && is_update;
    assign sigma     = r_spin_q ^ r_w[WT_W-1];
    assign word_cur  = r_queue[QPTR_W'(r_head + QPTR_W'(r_n))];
    assign nt_sel    = (i_rule_select == RULE_MAJ) ? r_idx : r_rem[SLOT_W-1:0];
    assign w_ext     = H_W'($signed(r_w));

    always_comb begin
        if (i_group_size == '0) begin
            q_eff = GRP_W'(1);
        end else if (i_group_size > GRP_W'(MAX_GROUP)) begin
            q_eff = GRP_W'(MAX_GROUP);
        end else begin
            q_eff = i_group_size;
        end
    end

    always_comb begin
        case (i_cmd.res)
            RES_SIGMA: res_spin = r_sg;
            RES_FIRST: res_spin = r_first;
            RES_ONE:   res_spin = 1'b1;
            RES_ZERO:  res_spin = 1'b0;
            RES_TIE:   res_spin = r_tie;
            RES_FLIP:  res_spin = r_cur ^ r_flip;
            default:   res_spin = r_cur;
        endcase
    end

    // Four restoring steps of the remainder per cycle.
    always_comb begin
        logic [DEG_W:0] rr;
        rem_next = r_rem;
        for (int b = 0; b < MOD_BITS; b++) begin
            rr = {rem_next, r_div[WORD_W-1-b]};
            if (rr >= {1'b0, r_deg}) rr = rr - {1'b0, r_deg};
            rem_next = rr[DEG_W-1:0];
        end
    end

    // Spin banks: one write and one read port, bank select in the top address bit.
    assign spin_re = i_cmd.rd_self || i_cmd.sp_rd;
    assign spin_ra = i_cmd.sp_rd ? {r_act, r_nt_q} : {r_act, r_node};
    assign spin_we = commit || (i_cmd.simple && (r_op == OP_WSPIN));
    assign spin_wa = commit ? {r_act ^ (r_op == OP_SYNC), r_node} : {r_act, r_node};
    assign spin_wd = commit ? res_spin : r_spin;

    always_ff @(posedge i_clk) begin
        if (spin_we) r_spin_mem[spin_wa] <= spin_wd;
        if (spin_re) r_spin_q <= r_spin_mem[spin_ra];
    end

    assign deg_we = i_cmd.clr_en || (i_cmd.simple && (r_op == OP_WDEG));
    assign deg_wa = i_cmd.clr_en ? r_clr_idx : r_node;
    assign deg_wd = i_cmd.clr_en ? '0 :
                    (r_deg_in > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_deg_in;

    always_ff @(posedge i_clk) begin
        if (deg_we) r_deg_mem[deg_wa] <= deg_wd;
        if (i_cmd.rd_self) r_deg_q <= r_deg_mem[r_node];
    end

    assign nt_we = i_cmd.simple && (r_op == OP_WEDGE)
                   && ({1'b0, r_slot} < (SLOT_W+1)'(MAX_DEGREE));

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            r_nt_mem[{r_node, r_slot}] <= r_nb;
            r_wt_mem[{r_node, r_slot}] <= r_wt;
        end
        if (i_cmd.nt_rd) begin
            r_nt_q <= r_nt_mem[{r_node, nt_sel}];
            r_wt_q <= r_wt_mem[{r_node, nt_sel}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.simple && (r_op == OP_PUSH) && (r_count < QCNT_W'(QUEUE_DEPTH))) begin
            r_queue[QPTR_W'(r_head + r_count[QPTR_W-1:0])] <= r_rw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_node   <= i_node;
            r_slot   <= i_slot;
            r_nb     <= i_neighbour;
            r_wt     <= i_edge_weight;
            r_spin   <= i_spin_in;
            r_deg_in <= i_degree_in;
            r_rw     <= i_random_word;
        end
        if (i_cmd.take_self) begin
            r_deg   <= r_deg_q;
            r_cur   <= r_spin_q;
            r_h     <= '0;
            r_idx   <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_sg    <= 1'b0;
            r_first <= 1'b0;
        end
        if (i_cmd.mod_start) begin
            r_div  <= word_cur;
            r_rem  <= '0;
            r_mcnt <= '0;
            r_n    <= r_n + 1'b1;
        end
        if (i_cmd.mod_step) begin
            r_div  <= r_div << MOD_BITS;
            r_rem  <= rem_next;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.sp_rd) r_w <= r_wt_q;
        if (i_cmd.sg_take) begin
            r_sg <= sigma;
            if (r_k == '0) r_first <= sigma;
        end
        if (i_cmd.acc) begin
            r_h   <= r_spin_q ? (r_h + w_ext) : (r_h - w_ext);
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.k_inc) r_k <= r_k + 1'b1;
        if (i_cmd.word_take) begin
            r_tie  <= word_cur[0];
            r_flip <= ({1'b0, word_cur[WORD_W-1:WORD_W-16]} < i_flip_chance);
            r_n    <= r_n + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_count   <= '0;
            r_head    <= '0;
            r_clr_idx <= '0;
            r_full    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd.clr_en) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.capture) r_full <= 1'b0;
            if (i_cmd.simple && (r_op == OP_SWAP)) r_act <= ~r_act;
            if (i_cmd.simple && (r_op == OP_PUSH)) begin
                if (r_count >= QCNT_W'(QUEUE_DEPTH)) begin
                    r_full <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (commit) begin
                r_head  <= QPTR_W'(r_head + QPTR_W'(r_n));
                r_count <= r_count - QCNT_W'(r_n);
            end
            if (i_cmd.finish) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_spin   <= commit ? res_spin :
                          (r_op == OP_READ) ? r_cur : 1'b0;
            r_o_status <= (is_update && i_cmd.abort) ? ST_SHORT :
                          r_full ? ST_FULL : ST_OK;
            r_o_used   <= commit ? r_n : '0;
            r_o_level  <= commit ? (r_count - QCNT_W'(r_n)) : r_count;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_spin_out    = r_o_spin;
    assign o_status      = r_o_status;
    assign o_words_used  = r_o_used;
    assign o_queue_level = r_o_level;

    always_comb begin
        o_sts          = '0;
        o_sts.clr_done = (r_clr_idx == NODE_W'(NODES - 1));
        o_sts.deg_zero = (r_deg == '0);
        o_sts.avail    = (r_count > QCNT_W'(r_n));
        o_sts.mod_done = (r_mcnt == MCNT_W'(MOD_STEPS - 1));
        o_sts.idx_last = ({1'b0, r_idx} == (r_deg - 1'b1));
        o_sts.h_zero   = (r_h == '0);
        o_sts.h_pos    = !r_h[H_W-1] && (r_h != '0);
        o_sts.sg_diff  = (r_sg != r_first);
        o_sts.k_last   = (({1'b0, r_k} + 1'b1) >= {1'b0, q_eff});
        o_sts.out_busy = r_ov && !i_out_ready;
        o_sts.op       = r_op;
        o_sts.rule     = i_rule_select;
    end

endmodule

// ----- src/signed_voter_node_update.sv -----
// Top level of the signed voter node update engine: configuration registers,
// controller and datapath. Depends on svnu_pkg, svnu_ctrl and svnu_dp.
//
// The engine takes one item at a time and returns exactly one result beat per
// item. After reset it clears the degree memory and takes no item during that
// pass; configuration writes are accepted throughout. An update first reads
// the node's own spin and degree, then per random draw runs a queue check, the
// four-bit-per-cycle modulo unit and the adjacency and spin look-up through the
// registered memory ports; a linear copy makes a single draw. A q-voter draw
// adds a compare of the opinion with the first one, and a group of q draws ends
// by taking the flip word when the draws disagree. Weighted majority walks the
// adjacency list. The result register frees the engine as soon as the beat is
// loaded, so a stalled output only holds the engine when a second result is
// ready before the first has been taken.
module signed_voter_node_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [2:0]                         i_opcode,
    input  logic [svnu_pkg::NODE_W-1:0]        i_node,
    input  logic [svnu_pkg::SLOT_W-1:0]        i_slot,
    input  logic [svnu_pkg::NODE_W-1:0]        i_neighbour,
    input  logic signed [svnu_pkg::WT_W-1:0]   i_edge_weight,
    input  logic                               i_spin_in,
    input  logic [svnu_pkg::DEG_W-1:0]         i_degree_in,
    input  logic [svnu_pkg::WORD_W-1:0]        i_random_word,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_spin_out,
    output logic [1:0]                         o_status,
    output logic [svnu_pkg::USED_W-1:0]        o_words_used,
    output logic [svnu_pkg::QCNT_W-1:0]        o_queue_level
);
    import svnu_pkg::*;

    logic [1:0]       r_rule_select;
    logic [GRP_W-1:0] r_group_size;
    logic [16:0]      r_flip_chance;
    logic             cfg_wr;
    t_cmd             cmd;
    t_sts             sts;

    // The APB port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_select <= RULE_LINEAR;
            r_group_size  <= GRP_W'(1);
            r_flip_chance <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RULE:  r_rule_select <= pwdata[1:0];
                REG_GROUP: r_group_size  <= pwdata[GRP_W-1:0];
                REG_FLIP:  r_flip_chance <= pwdata[16:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RULE:  prdata = {30'd0, r_rule_select};
            REG_GROUP: prdata = {{(32-GRP_W){1'b0}}, r_group_size};
            REG_FLIP:  prdata = {15'd0, r_flip_chance};
            default:   prdata = '0;
        endcase
    end

    svnu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    svnu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rule_select (r_rule_select),
        .i_group_size  (r_group_size),
        .i_flip_chance (r_flip_chance),
        .i_opcode      (i_opcode),
        .i_node        (i_node),
        .i_slot        (i_slot),
        .i_neighbour   (i_neighbour),
        .i_edge_weight (i_edge_weight),
        .i_spin_in     (i_spin_in),
        .i_degree_in   (i_degree_in),
        .i_random_word (i_random_word),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_spin_out    (o_spin_out),
        .o_status      (o_status),
        .o_words_used  (o_words_used),
        .o_queue_level (o_queue_level)
    );

    // One item at a time: an accepted beat always closes the input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while an item was in progress");

    // An aborted update neither consumes words nor reports a spin.
    a_abort_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SHORT)) |-> ((o_words_used == '0) && !o_spin_out))
        else $error("aborted update reported words or a spin");

    // A dropped push uses no words.
    a_full_no_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_words_used == '0))
        else $error("dropped push reported words used");

    // The queue level never exceeds the queue depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_queue_level <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue level beyond depth");

endmodule
